// File: rtl/countdown_timer_fractional_prescaler_assert.svh
// assertion macros shared by the timer modules
`ifndef COUNTDOWN_TIMER_FRACTIONAL_PRESCALER_ASSERT_SVH
`define COUNTDOWN_TIMER_FRACTIONAL_PRESCALER_ASSERT_SVH

// clocked check, masked while reset is asserted
`define CTFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define CTFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/ctfp_pkg.sv
// shared types, widths and constants of the countdown timer
package ctfp_pkg;

  // field and register widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned OffW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpsW     = 24;
  localparam int unsigned RateW    = 16;
  localparam int unsigned KW       = RateW + 1;
  localparam int unsigned ProdW    = CpsW + KW;
  localparam int unsigned DivCntW  = $clog2(ProdW + 1);
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // configuration reset values and the first prescaler mark
  localparam logic [CpsW-1:0]  CpsReset  = 24'd1000000;
  localparam logic [RateW-1:0] RateReset = 16'd10000;
  localparam logic [CpsW-1:0]  MarkReset = CpsW'((64'(CpsReset) * 64'd2) / 64'(RateReset));
  localparam logic [RateW-1:0] IdoneReset = 16'd1;

  // countdown constants
  localparam logic [15:0] MinTimeout = 16'd8;
  localparam int unsigned CtrlStartBit = 0;

  // item kinds
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  // register byte offsets
  localparam logic [OffW-1:0] OFF_TMO_LO   = 3'd0;
  localparam logic [OffW-1:0] OFF_TMO_HI   = 3'd1;
  localparam logic [OffW-1:0] OFF_SPARE_LO = 3'd2;
  localparam logic [OffW-1:0] OFF_SPARE_HI = 3'd3;
  localparam logic [OffW-1:0] OFF_SPARE_B  = 3'd4;
  localparam logic [OffW-1:0] OFF_CTRL     = 3'd5;

  // configuration register index, taken from paddr bit 2
  localparam logic CFG_CPS  = 1'b0;
  localparam logic CFG_RATE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic item_go;
    logic prod_load;
    logic div_step;
  } ctfp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tick_hit;
    logic div_last;
  } ctfp_status_t;

endpackage

// File: rtl/ctfp_in_if.sv
// input request channel: bus access or source tick
interface ctfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctfp_pkg::FuncW-1:0]    func;
  logic [ctfp_pkg::OffW-1:0]     reg_offset;
  logic [ctfp_pkg::ByteW-1:0]    write_data;
  logic                          irq_accepted;

  modport source (output valid, func, reg_offset, write_data, irq_accepted, input ready);
  modport sink   (input valid, func, reg_offset, write_data, irq_accepted, output ready);
endinterface

// File: rtl/ctfp_out_if.sv
// result channel: read data, interrupt request, running flag
interface ctfp_out_if;
  logic                       valid;
  logic                       ready;
  logic [ctfp_pkg::ByteW-1:0] read_data;
  logic                       irq_request;
  logic                       running;

  modport source (output valid, read_data, irq_request, running, input ready);
  modport sink   (input valid, read_data, irq_request, running, output ready);
endinterface

// File: rtl/ctfp_apb_regs.sv
// apb configuration registers for the prescaler
module ctfp_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctfp_pkg::ApbAddrW-1:0] paddr,
  input  logic [ctfp_pkg::ApbDataW-1:0] pwdata,
  output logic [ctfp_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [ctfp_pkg::CpsW-1:0]     cps_o,
  output logic [ctfp_pkg::RateW-1:0]    rate_o
);
  import ctfp_pkg::*;

  logic [CpsW-1:0]  cps_q;
  logic [RateW-1:0] rate_q;
  logic             wr_en;
  logic             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q  <= CpsReset;
      rate_q <= RateReset;
    end else if (wr_en) begin
      unique case (idx)
        CFG_CPS:  cps_q  <= pwdata[CpsW-1:0];
        CFG_RATE: rate_q <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      CFG_CPS:  prdata = ApbDataW'(cps_q);
      CFG_RATE: prdata = ApbDataW'(rate_q);
      default:  prdata = '0;
    endcase
  end

  assign cps_o  = cps_q;
  assign rate_o = rate_q;

endmodule

// File: rtl/ctfp_datapath.sv
// timer registers, countdown, prescaler counters and mark divider
`include "countdown_timer_fractional_prescaler_assert.svh"

module ctfp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctfp_pkg::ctfp_cmd_t         cmd_i,
  output ctfp_pkg::ctfp_status_t      status_o,
  input  logic [ctfp_pkg::FuncW-1:0]  func_i,
  input  logic [ctfp_pkg::OffW-1:0]   reg_offset_i,
  input  logic [ctfp_pkg::ByteW-1:0]  write_data_i,
  input  logic                        irq_accepted_i,
  input  logic [ctfp_pkg::CpsW-1:0]   cps_i,
  input  logic [ctfp_pkg::RateW-1:0]  rate_i,
  output logic [ctfp_pkg::ByteW-1:0]  read_data_o,
  output logic                        irq_request_o,
  output logic                        running_o
);
  import ctfp_pkg::*;

  // bus registers and countdown
  logic [15:0]       tmo_q, tmo_d;
  logic [15:0]       spare_q, spare_d;
  logic [7:0]        spare_b_q, spare_b_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [15:0]       ticks_q, ticks_d;
  logic              active_q, active_d;
  // prescaler
  logic [CpsW-1:0]   src_q, src_d;
  logic [CpsW-1:0]   mark_q, mark_d;
  logic [RateW-1:0]  idone_q, idone_d;
  logic [CpsW-1:0]   cps_lat_q;
  logic [RateW-1:0]  rate_lat_q;
  // divider
  logic [ProdW-1:0]  dvd_q;
  logic [RateW-1:0]  rem_q;
  logic [CpsW-1:0]   quo_q;
  logic [DivCntW-1:0] cnt_q;
  // result register
  logic [ByteW-1:0]  rd_q, rd_d;
  logic              req_q, req_d;
  logic              run_q;

  logic [RateW-1:0]  rate_eff;
  logic              tick_hit;
  logic [RateW-1:0]  k_inc;
  logic              k_wrap;
  logic [15:0]       ticks_dec;
  logic [CpsW-1:0]   src_base;
  logic [ProdW-1:0]  prod;
  logic [RateW:0]    trial;
  logic              qbit;
  logic [RateW:0]    trial_sub;

  // prescaler decode
  assign rate_eff  = (rate_i == '0) ? RateW'(1) : rate_i;
  assign tick_hit  = (func_i == FUNC_TICK) && (src_q == mark_q);
  assign k_inc     = idone_q + RateW'(1);
  assign k_wrap    = (k_inc == rate_eff);
  assign ticks_dec = (active_q && (ticks_q != '0)) ? ticks_q - 16'd1 : ticks_q;
  assign src_base  = (tick_hit && k_wrap) ? '0 : src_q;

  // item processing
  always_comb begin
    tmo_d     = tmo_q;
    spare_d   = spare_q;
    spare_b_d = spare_b_q;
    ctrl_d    = ctrl_q;
    ticks_d   = ticks_q;
    active_d  = active_q;
    src_d     = src_q;
    idone_d   = idone_q;
    rd_d      = '0;
    req_d     = 1'b0;
    if (cmd_i.item_go) begin
      unique case (func_i)
        FUNC_TICK: begin
          if (tick_hit) begin
            idone_d = k_wrap ? '0 : k_inc;
            ticks_d = ticks_dec;
          end
          src_d = src_base + CpsW'(1);
          if (active_q && (ticks_d == '0)) begin
            req_d = 1'b1;
            if (irq_accepted_i) begin
              active_d = 1'b0;
            end
          end
        end
        FUNC_READ: begin
          unique case (reg_offset_i)
            OFF_TMO_LO:   rd_d = tmo_q[7:0];
            OFF_TMO_HI:   rd_d = tmo_q[15:8];
            OFF_SPARE_LO: rd_d = spare_q[7:0];
            OFF_SPARE_HI: rd_d = spare_q[15:8];
            OFF_SPARE_B:  rd_d = spare_b_q;
            OFF_CTRL:     rd_d = ctrl_q;
            default:      rd_d = '0;
          endcase
        end
        FUNC_WRITE: begin
          unique case (reg_offset_i)
            OFF_TMO_LO:   tmo_d[7:0]    = write_data_i;
            OFF_TMO_HI:   tmo_d[15:8]   = write_data_i;
            OFF_SPARE_LO: spare_d[7:0]  = write_data_i;
            OFF_SPARE_HI: spare_d[15:8] = write_data_i;
            OFF_SPARE_B:  spare_b_d     = write_data_i;
            OFF_CTRL: begin
              ctrl_d = write_data_i;
              if (write_data_i[CtrlStartBit]) begin
                ticks_d  = (tmo_q < MinTimeout) ? MinTimeout : tmo_q;
                active_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q     <= '0;
      spare_q   <= '0;
      spare_b_q <= '0;
      ctrl_q    <= '0;
      ticks_q   <= '0;
      active_q  <= 1'b0;
      src_q     <= '0;
      idone_q   <= IdoneReset;
      mark_q    <= MarkReset;
      cnt_q     <= '0;
    end else begin
      tmo_q     <= tmo_d;
      spare_q   <= spare_d;
      spare_b_q <= spare_b_d;
      ctrl_q    <= ctrl_d;
      ticks_q   <= ticks_d;
      active_q  <= active_d;
      src_q     <= src_d;
      idone_q   <= idone_d;
      mark_q    <= mark_d;
      if (cmd_i.prod_load) begin
        cnt_q <= DivCntW'(ProdW);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end
    end
  end

  // snapshot of the prescaler settings at a mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_lat_q  <= CpsReset;
      rate_lat_q <= RateW'(1);
    end else if (cmd_i.item_go && tick_hit) begin
      cps_lat_q  <= cps_i;
      rate_lat_q <= rate_eff;
    end
  end

  // next mark numerator: cps * (k + 1)
  assign prod = ProdW'(cps_lat_q) * ProdW'(KW'(idone_q) + KW'(1));

  // restoring divider step, one quotient bit a cycle
  assign trial     = {rem_q, dvd_q[ProdW-1]};
  assign trial_sub = trial - {1'b0, rate_lat_q};
  assign qbit      = (trial >= {1'b0, rate_lat_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.prod_load) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? trial_sub[RateW-1:0] : trial[RateW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      dvd_q <= prod;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[ProdW-2:0], 1'b0};
      quo_q <= {quo_q[CpsW-2:0], qbit};
    end
  end

  // new mark on the last divider step
  assign mark_d = (cmd_i.div_step && status_o.div_last) ? {quo_q[CpsW-2:0], qbit} : mark_q;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_go) begin
      rd_q  <= rd_d;
      req_q <= req_d;
      run_q <= active_d;
    end
  end

  assign status_o.tick_hit = tick_hit;
  assign status_o.div_last = (cnt_q == DivCntW'(1));
  assign read_data_o       = rd_q;
  assign irq_request_o     = req_q;
  assign running_o         = run_q;

  // checks
  `CTFP_ASSERT(a_step_needs_count, cmd_i.div_step |-> cnt_q != '0, "divider stepped with no count")
  `CTFP_ASSERT(a_load_sets_count, cmd_i.prod_load |=> cnt_q == DivCntW'(ProdW), "divider count not loaded")
  `CTFP_ASSERT(a_rem_below_rate, cmd_i.div_step |=> rem_q < rate_lat_q, "remainder not below divisor")

endmodule

// File: rtl/ctfp_ctrl.sv
// controller: request handshake and mark computation sequencing
`include "countdown_timer_fractional_prescaler_assert.svh"

module ctfp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ctfp_pkg::ctfp_cmd_t     cmd_o,
  input  ctfp_pkg::ctfp_status_t  status_i
);
  import ctfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   item_go;

  // take a request when idle and the result slot frees up
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign item_go    = in_valid_i && in_ready_o;

  // state sequencing
  always_comb begin
    state_d         = state_q;
    cmd_o.item_go   = item_go;
    cmd_o.prod_load = 1'b0;
    cmd_o.div_step  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_go && status_i.tick_hit) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.prod_load = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `CTFP_ASSERT(a_mark_starts_mul, item_go && status_i.tick_hit |=> state_q == S_MUL, "mark hit did not start multiply")
  `CTFP_ASSERT(a_mul_then_div, state_q == S_MUL |=> state_q == S_DIV, "multiply not followed by divide")
  `CTFP_ASSERT_ALWAYS(a_busy_blocks_input, state_q != S_IDLE |-> !in_ready_o, "request taken while busy")

endmodule

// File: rtl/countdown_timer_fractional_prescaler.sv
// Countdown timer with fractional prescaler: one result per request, registered in the cycle after acceptance.
// Reads, writes and ticks that miss the prescaler mark: one request per cycle while results are taken.
// A tick that hits the mark holds off the next request while the controller multiplies
// cps*(k+1) and runs 41 restoring divider steps for the next mark.
// Reset (async, active low) clears the registers and countdown; the first mark is preset.
module countdown_timer_fractional_prescaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ctfp_in_if.sink                       in_i,
  ctfp_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctfp_pkg::ApbAddrW-1:0] paddr,
  input  logic [ctfp_pkg::ApbDataW-1:0] pwdata,
  output logic [ctfp_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import ctfp_pkg::*;

  ctfp_cmd_t        cmd;
  ctfp_status_t     status;
  logic [CpsW-1:0]  cps;
  logic [RateW-1:0] rate;

  // configuration port
  ctfp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cps_o   (cps),
    .rate_o  (rate)
  );

  // controller
  ctfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath
  ctfp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (in_i.func),
    .reg_offset_i   (in_i.reg_offset),
    .write_data_i   (in_i.write_data),
    .irq_accepted_i (in_i.irq_accepted),
    .cps_i          (cps),
    .rate_i         (rate),
    .read_data_o    (out_o.read_data),
    .irq_request_o  (out_o.irq_request),
    .running_o      (out_o.running)
  );

endmodule

// File: dv/countdown_timer_fractional_prescaler_tb.sv
// testbench for the countdown timer: predicts every reply, checks it, sweeps prescaler settings
module countdown_timer_fractional_prescaler_tb;
  import ctfp_pkg::*;

  localparam int          CLK_HALF       = 5;
  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 50;
  localparam int          DRAIN_LIMIT    = 20000;
  localparam int          WATCHDOG_TIME  = 8000000;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          PHASE_REQUESTS = 250;
  localparam logic [23:0] CPS_AT_RESET   = 24'd1000000;
  localparam logic [15:0] RATE_AT_RESET  = 16'd10000;
  localparam logic [23:0] CPS_MAX        = 24'hFFFFFF;
  localparam logic [15:0] RATE_MAX       = 16'hFFFF;
  localparam logic [15:0] SHORTEST_COUNT = 16'd8;
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
  localparam logic [2:0]  OFF_UNUSED_LO  = 3'd6;
  localparam logic [2:0]  OFF_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             irq_request;
    logic             running;
  } timer_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  ctfp_in_if  in_ch ();
  ctfp_out_if out_ch ();

  countdown_timer_fractional_prescaler uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predicted timer state and prescaler settings
  logic [23:0] cfg_cycles_per_sec;
  logic [15:0] cfg_tick_rate;
  logic [15:0] timeout_q;
  logic [15:0] spare_word_q;
  logic [7:0]  spare_byte_q;
  logic [7:0]  control_q;
  logic [15:0] remaining_q;
  logic        run_q;
  logic [23:0] src_count_q;
  logic [23:0] mark_q;
  logic [15:0] intervals_q;

  timer_reply_t timer_replies[$];

  // idling knobs and run statistics
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles_req = 0;
  int hold_left = 0;
  int n_mismatch = 0;
  int n_sent = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_unused = 0;
  int n_steps = 0;
  int n_irq_taken = 0;
  int n_cfg_writes = 0;

  // one prescaler mark reached: next interval, next mark, one countdown step
  task automatic prescaler_advance();
    logic [16:0] divisor;
    logic [63:0] product;
    divisor = (cfg_tick_rate == 16'd0) ? 17'd1 : {1'b0, cfg_tick_rate};
    intervals_q = intervals_q + 16'd1;
    if ({1'b0, intervals_q} == divisor) begin
      intervals_q = 16'd0;
      src_count_q = 24'd0;
    end
    product = 64'(cfg_cycles_per_sec) * (64'(intervals_q) + 64'd1);
    mark_q = 24'(product / 64'(divisor));
    if (run_q && remaining_q != 16'd0) remaining_q = remaining_q - 16'd1;
    n_steps++;
  endtask

  task automatic reset_timer_state();
    cfg_cycles_per_sec = CPS_AT_RESET;
    cfg_tick_rate = RATE_AT_RESET;
    timeout_q = '0;
    spare_word_q = '0;
    spare_byte_q = '0;
    control_q = '0;
    remaining_q = '0;
    run_q = 1'b0;
    src_count_q = '0;
    mark_q = '0;
    intervals_q = '0;
    prescaler_advance();
    n_steps = 0;
  endtask

  function automatic logic [7:0] register_byte(input logic [2:0] off);
    case (off)
      OFF_TMO_LO:   return timeout_q[7:0];
      OFF_TMO_HI:   return timeout_q[15:8];
      OFF_SPARE_LO: return spare_word_q[7:0];
      OFF_SPARE_HI: return spare_word_q[15:8];
      OFF_SPARE_B:  return spare_byte_q;
      OFF_CTRL:     return control_q;
      default:      return 8'h00;
    endcase
  endfunction

  // apply one accepted request to the timer state and queue its reply
  task automatic apply_timer_request(input logic [1:0] f, input logic [2:0] off,
                                     input logic [7:0] data, input logic acc);
    timer_reply_t reply;
    reply = '0;
    case (f)
      FUNC_TICK: begin
        if (src_count_q == mark_q) prescaler_advance();
        src_count_q = src_count_q + 24'd1;
        if (run_q && remaining_q == 16'd0) begin
          reply.irq_request = 1'b1;
          if (acc) begin
            run_q = 1'b0;
            n_irq_taken++;
          end
        end
        n_ticks++;
      end
      FUNC_READ: begin
        reply.read_data = register_byte(off);
        n_reads++;
      end
      FUNC_WRITE: begin
        case (off)
          OFF_TMO_LO:   timeout_q[7:0] = data;
          OFF_TMO_HI:   timeout_q[15:8] = data;
          OFF_SPARE_LO: spare_word_q[7:0] = data;
          OFF_SPARE_HI: spare_word_q[15:8] = data;
          OFF_SPARE_B:  spare_byte_q = data;
          OFF_CTRL: begin
            control_q = data;
            if (data[CtrlStartBit]) begin
              remaining_q = (timeout_q < SHORTEST_COUNT) ? SHORTEST_COUNT : timeout_q;
              run_q = 1'b1;
            end
          end
          default: ;
        endcase
        n_writes++;
      end
      default: n_unused++;
    endcase
    reply.running = run_q;
    timer_replies.push_back(reply);
    n_sent++;
  endtask

  // offer one request, with a random gap first, and wait for acceptance
  task automatic send_request(input logic [1:0] f, input logic [2:0] off,
                              input logic [7:0] data, input logic acc);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.reg_offset   <= off;
    in_ch.write_data   <= data;
    in_ch.irq_accepted <= acc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    apply_timer_request(f, off, data, acc);
  endtask

  // stop offering, wait for every reply, then let a slow mark update finish
  task automatic wait_idle();
    int waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (timer_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb read of one prescaler register, checked against the predicted value
  task automatic cfg_check(input logic sel);
    logic [31:0] want;
    want = (sel == CFG_CPS) ? {8'h00, cfg_cycles_per_sec} : {16'h0000, cfg_tick_rate};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      n_mismatch++;
      if (n_mismatch <= REPORT_LIMIT)
        $display("register %0d read: expected %08h, got %08h", sel, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // apb write of one prescaler register, then read it back
  task automatic cfg_set(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (sel == CFG_CPS) cfg_cycles_per_sec = value[23:0];
    else cfg_tick_rate = value[15:0];
    n_cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    cfg_check(sel);
  endtask

  // pick a setting that wraps at the next mark, so marks then come every ticks_per_step ticks
  task automatic retarget_prescaler(input int ticks_per_step);
    logic [16:0] wrap_at;
    logic [15:0] rate;
    wrap_at = {1'b0, intervals_q} + 17'd1;
    if (wrap_at <= 17'd65535) begin
      rate = wrap_at[15:0];
      // zero rate behaves as one
      if (rate == 16'd1 && $urandom_range(1) == 1) rate = 16'd0;
      cfg_set(CFG_RATE, {16'h0000, rate});
      cfg_set(CFG_CPS, {8'h00, 24'(wrap_at * 17'(ticks_per_step))});
    end
  endtask

  // reply checker
  always @(posedge clk_i) begin
    timer_reply_t want;
    timer_reply_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.read_data   = out_ch.read_data;
      got.irq_request = out_ch.irq_request;
      got.running     = out_ch.running;
      if (timer_replies.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= REPORT_LIMIT)
          $display("reply with no request outstanding: read_data %02h irq %0b running %0b",
                   got.read_data, got.irq_request, got.running);
      end else begin
        want = timer_replies.pop_front();
        if (got.read_data !== want.read_data || got.irq_request !== want.irq_request ||
            got.running !== want.running) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_LIMIT)
            $display("reply %0d: expected read_data %02h irq %0b running %0b, got %02h %0b %0b",
                     n_sent - timer_replies.size(), want.read_data, want.irq_request,
                     want.running, got.read_data, got.irq_request, got.running);
        end
      end
    end
  end

  // reply ready: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // prescaler registers come out of reset at their defaults
  task automatic test_config_reset();
    cfg_check(CFG_CPS);
    cfg_check(CFG_RATE);
  endtask

  // byte registers: extremes, unused offsets, unused request kind
  task automatic test_register_file();
    send_request(FUNC_READ, OFF_TMO_LO, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_CTRL, 8'hFF, 1'b1);
    send_request(FUNC_READ, OFF_UNUSED_HI, 8'h00, 1'b0);
    send_request(FUNC_WRITE, OFF_TMO_LO, 8'hFF, 1'b0);
    send_request(FUNC_WRITE, OFF_TMO_HI, 8'h00, 1'b1);
    send_request(FUNC_WRITE, OFF_SPARE_LO, 8'h00, 1'b0);
    send_request(FUNC_WRITE, OFF_SPARE_HI, 8'hFF, 1'b0);
    send_request(FUNC_WRITE, OFF_SPARE_B, 8'hFF, 1'b0);
    send_request(FUNC_WRITE, OFF_UNUSED_LO, 8'hFF, 1'b0);
    send_request(FUNC_WRITE, OFF_UNUSED_HI, 8'hFF, 1'b0);
    send_request(FUNC_UNUSED, OFF_CTRL, 8'hFF, 1'b1);
    send_request(FUNC_READ, OFF_TMO_LO, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_TMO_HI, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_SPARE_LO, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_SPARE_HI, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_SPARE_B, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_UNUSED_LO, 8'h00, 1'b0);
    send_request(FUNC_READ, OFF_UNUSED_HI, 8'h00, 1'b0);
  endtask

  // control without start, accept with no request, start from a short timeout
  task automatic test_start_controls();
    send_request(FUNC_WRITE, OFF_CTRL, 8'hFE, 1'b0);
    send_request(FUNC_TICK, OFF_CTRL, 8'h00, 1'b1);
    send_request(FUNC_WRITE, OFF_TMO_LO, 8'h00, 1'b0);
    send_request(FUNC_WRITE, OFF_CTRL, 8'h01, 1'b0);
    send_request(FUNC_READ, OFF_CTRL, 8'h00, 1'b0);
    send_request(FUNC_TICK, OFF_TMO_LO, 8'hFF, 1'b1);
  endtask

  // mostly programmed countdowns run to the interrupt, some noise and aborted runs
  task automatic test_random_programs(input int n_requests);
    int first;
    int budget;
    int choice;
    logic [7:0] ctrl;
    first = n_sent;
    while (n_sent - first < n_requests) begin
      if ($urandom_range(99) < 20) begin
        send_request(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom),
                     1'($urandom));
      end else begin
        send_request(FUNC_WRITE, OFF_TMO_LO,
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12)), 1'b0);
        send_request(FUNC_WRITE, OFF_TMO_HI,
                     ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00, 1'b0);
        ctrl = 8'($urandom);
        ctrl[CtrlStartBit] = ($urandom_range(9) != 0);
        send_request(FUNC_WRITE, OFF_CTRL, ctrl, 1'($urandom));
        budget = 80;
        while (run_q && budget > 0) begin
          choice = $urandom_range(99);
          if (choice < 80)
            send_request(FUNC_TICK, 3'($urandom_range(7)), 8'($urandom),
                         ($urandom_range(99) < 35));
          else if (choice < 92)
            send_request(FUNC_READ, 3'($urandom_range(7)), 8'($urandom), 1'($urandom));
          else
            send_request(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom),
                         1'($urandom));
          budget--;
        end
      end
    end
  endtask

  // replies held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles_req = 300;
    test_random_programs(40);
  endtask

  // extreme prescaler settings, including overflowing marks and a zero rate
  task automatic test_config_extremes();
    cfg_set(CFG_CPS, {8'h00, CPS_MAX});
    cfg_set(CFG_RATE, 32'd1);
    test_random_programs(25);
    wait_idle();
    cfg_set(CFG_RATE, {16'h0000, RATE_MAX});
    test_random_programs(25);
    wait_idle();
    cfg_set(CFG_CPS, 32'd1);
    cfg_set(CFG_RATE, 32'd0);
    test_random_programs(25);
    wait_idle();
  endtask

  // watchdog
  initial begin
    #(WATCHDOG_TIME);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.func         = '0;
    in_ch.reg_offset   = '0;
    in_ch.write_data   = '0;
    in_ch.irq_accepted = 1'b0;
    out_ch.ready       = 1'b0;
    reset_timer_state();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_config_reset();
    test_register_file();
    test_start_controls();
    wait_idle();

    // idling phases, each on a fresh prescaler setting
    retarget_prescaler(1);
    test_random_programs(PHASE_REQUESTS);
    wait_idle();
    retarget_prescaler(2);
    gap_pct = 65;
    test_random_programs(PHASE_REQUESTS);
    wait_idle();
    retarget_prescaler(1);
    gap_pct = 0;
    stall_pct = 65;
    test_random_programs(PHASE_REQUESTS);
    wait_idle();
    retarget_prescaler(3);
    gap_pct = 11;
    stall_pct = 11;
    test_random_programs(PHASE_REQUESTS);
    wait_idle();

    test_backpressure();
    wait_idle();
    test_config_extremes();

    if (timer_replies.size() != 0) begin
      n_mismatch += timer_replies.size();
      $display("%0d replies never arrived", timer_replies.size());
    end
    $display("Covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d unused kinds",
             n_sent, n_ticks, n_reads, n_writes, n_unused);
    $display("%0d countdown steps, %0d interrupts taken, %0d prescaler register writes",
             n_steps, n_irq_taken, n_cfg_writes);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
